>>> rtl/core/sli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and codes for the sorted list insert/delete block.
// ----------------------------------------------------------------------------
package sli_pkg;

   typedef logic signed [7:0] value_type;
   typedef logic [2:0]        status_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam status_type ST_INSERTED  = 3'd0;
   localparam status_type ST_DELETED   = 3'd1;
   localparam status_type ST_NOT_FOUND = 3'd2;
   localparam status_type ST_EMPTY     = 3'd3;
   localparam status_type ST_FULL      = 3'd4;

   // chain signals handed from one cell to the next
   typedef struct packed {
      logic gt;     // this cell is occupied and holds a value below the word
      logic found;  // delete target located in this cell or an earlier one
   } link_type;

endpackage

>>> rtl/core/sli_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_cell
// One slot of the sorted row: compares, then keeps, takes or shifts an entry.
// ----------------------------------------------------------------------------
module sli_cell #(
   parameter int CW    = 5,
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  logic                update,
   input  logic                op,
   input  sli_pkg::value_type  value,
   input  logic [CW-1:0]       count,
   input  sli_pkg::link_type   link_in,
   output sli_pkg::link_type   link_out,
   input  sli_pkg::value_type  left_entry,
   input  sli_pkg::value_type  right_entry,
   output sli_pkg::value_type  entry
);

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   sli_pkg::value_type entry_ff;
   sli_pkg::value_type entry_in;
   logic               occupied;
   logic               gt;
   logic               pos_here;

   assign occupied = IDX < count;
   assign gt       = occupied && (value > entry_ff);
   assign pos_here = link_in.gt && !gt;

   assign link_out.gt    = gt;
   assign link_out.found = link_in.found ||
                           (pos_here && occupied && (entry_ff == value));

   always_comb begin
      if (gt) begin
         entry_in = entry_ff;
      end else if (op == sli_pkg::OP_DELETE) begin
         entry_in = right_entry;
      end else if (link_in.gt) begin
         entry_in = value;
      end else begin
         entry_in = left_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

>>> rtl/core/sorted_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Sorted multiset of signed bytes with insert and delete, one cell per slot.
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one result word in the next cycle, held
// in an output register; a new word is taken in any cycle in which that
// register is empty or its result is taken, so a stalled result stalls the
// input. Every cell compares the incoming value against its entry in
// parallel; the insert or delete position and the delete hit ripple down the
// row of CAPACITY cells, and that chain sets the clock period. The reported count wraps at
// 5 bits.
module sorted_list_insert_delete #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  sli_pkg::value_type req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [4:0]         rsp_count
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic                 rsp_valid_ff;
   sli_pkg::status_type  status_ff;
   sli_pkg::status_type  status_in;
   logic [4:0]           rsp_count_ff;
   logic [CW+4:0]        count_wide;
   logic                 accept;
   logic                 update;
   logic                 full;
   logic                 found;

   sli_pkg::link_type    links   [CAPACITY+1];
   sli_pkg::value_type   entries [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff >= CAP;

   assign links[0].gt    = 1'b1;
   assign links[0].found = 1'b0;
   assign found          = links[CAPACITY].found;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         sli_cell #(
            .CW    (CW),
            .INDEX (i)
         ) u_cell (
            .clock       (clock),
            .update      (update),
            .op          (req_opcode),
            .value       (req_value),
            .count       (count_ff),
            .link_in     (links[i]),
            .link_out    (links[i+1]),
            .left_entry  (entries[(i == 0) ? 0 : i - 1]),
            .right_entry (entries[(i == CAPACITY - 1) ? i : i + 1]),
            .entry       (entries[i])
         );
      end
   endgenerate

   always_comb begin
      update    = 1'b0;
      count_in  = count_ff;
      status_in = sli_pkg::ST_INSERTED;
      if (req_opcode == sli_pkg::OP_INSERT) begin
         if (full) begin
            status_in = sli_pkg::ST_FULL;
         end else begin
            update    = accept;
            count_in  = count_ff + CW'(1);
            status_in = sli_pkg::ST_INSERTED;
         end
      end else begin
         if (count_ff == '0) begin
            status_in = sli_pkg::ST_EMPTY;
         end else if (found) begin
            update    = accept;
            count_in  = count_ff - CW'(1);
            status_in = sli_pkg::ST_DELETED;
         end else begin
            status_in = sli_pkg::ST_NOT_FOUND;
         end
      end
   end

   assign count_wide = {5'd0, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         rsp_count_ff <= count_wide[4:0];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = rsp_count_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP)
      else $error("entry count above capacity");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode == sli_pkg::OP_INSERT) && !full
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow count");

   a_miss_holds : assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode == sli_pkg::OP_DELETE) && !found
      |=> $stable(count_ff))
      else $error("missed delete changed count");

   a_status_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> status_ff <= sli_pkg::ST_FULL)
      else $error("status code out of range");

endmodule
